// File: hw/rtl/tbr_pkg.sv
// Shared constants for the triangle bounding-box rasterizer.
`timescale 1ns / 1ps
package tbr_pkg;
  localparam int unsigned VTX_W      = 19;
  localparam int unsigned PIX_W      = 15;
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned STEP_W     = 18;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  localparam int unsigned COORD_FRAC_BITS_DEF = 16;
  localparam int unsigned MAX_FB_DIM_DEF      = 4096;

  localparam logic [CFG_IDX_W-1:0] CFG_FB_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FB_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_BASE      = CFG_IDX_W'(4);

  localparam logic [DIM_W-1:0]  FB_WIDTH_RST  = DIM_W'(256);
  localparam logic [DIM_W-1:0]  FB_HEIGHT_RST = DIM_W'(256);
  localparam logic [STEP_W-1:0] X_STEP_RST    = STEP_W'(512);
  localparam logic [STEP_W-1:0] Y_STEP_RST    = STEP_W'(512);

  localparam logic signed [PIX_W-1:0] PIX_MAX = PIX_W'(16383);
  localparam logic signed [PIX_W-1:0] PIX_MIN = PIX_W'(-16384);

  localparam logic OP_LOAD = 1'b0;
endpackage

// File: hw/rtl/tbr_if.sv
// Valid/ready channel interfaces for vertex input and sample results.
`timescale 1ns / 1ps
interface tbr_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic signed [tbr_pkg::VTX_W-1:0] vertex_a_x;
  logic signed [tbr_pkg::VTX_W-1:0] vertex_a_y;
  logic signed [tbr_pkg::VTX_W-1:0] vertex_b_x;
  logic signed [tbr_pkg::VTX_W-1:0] vertex_b_y;
  logic signed [tbr_pkg::VTX_W-1:0] vertex_c_x;
  logic signed [tbr_pkg::VTX_W-1:0] vertex_c_y;
  modport source(output valid, opcode, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                 vertex_c_x, vertex_c_y, input ready);
  modport sink(input valid, opcode, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y, output ready);
endinterface

interface tbr_out_if;
  logic valid;
  logic ready;
  logic covered;
  logic signed [tbr_pkg::PIX_W-1:0] pixel_x;
  logic signed [tbr_pkg::PIX_W-1:0] pixel_y;
  logic outside;
  logic [tbr_pkg::ADDR_W-1:0] pixel_address;
  logic done_res;
  modport source(output valid, covered, pixel_x, pixel_y, outside, pixel_address, done_res,
                 input ready);
  modport sink(input valid, covered, pixel_x, pixel_y, outside, pixel_address, done_res,
               output ready);
endinterface

// File: hw/rtl/tbr_mul.sv
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module tbr_mul #(
  parameter int unsigned MW = 21
) (
  input  logic                   clk_i,
  input  logic signed [MW-1:0]   a_i,
  input  logic signed [MW-1:0]   b_i,
  output logic signed [2*MW-1:0] prod_o
);
  logic signed [2*MW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;
endmodule

// File: hw/rtl/triangle_bbox_rasterizer.sv
// Triangle bounding-box rasterizer: sequencer around one shared multiplier.
// Load: accepted, then busy in S_D0, S_D1 and S_D2 to form the edge divisor; no result.
// Advance: result registered at the end of S_A0 through S_A8 (seven products through the one
// multiplier); next item accepted only once the result beat is taken.
// Advance with the walk finished: result in the next cycle.
// Reset: async, active low; control/config registers reset, walk idle, no result pending.
`timescale 1ns / 1ps
module triangle_bbox_rasterizer #(
  parameter int unsigned COORD_FRAC_BITS = tbr_pkg::COORD_FRAC_BITS_DEF,
  parameter int unsigned MAX_FB_DIM      = tbr_pkg::MAX_FB_DIM_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tbr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tbr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  tbr_in_if.sink                          in_i,
  tbr_out_if.source                       res_o
);
  localparam int unsigned VW  = tbr_pkg::VTX_W;
  localparam int unsigned DW  = tbr_pkg::VTX_W + 1;
  localparam int unsigned F   = COORD_FRAC_BITS;
  localparam int unsigned PW  = (F + 2 > DW) ? F + 2 : DW;
  localparam int unsigned MXW = $clog2(MAX_FB_DIM + 1);
  localparam int unsigned CW  = (MXW > tbr_pkg::DIM_W) ? MXW : tbr_pkg::DIM_W;
  localparam int unsigned M0  = (PW + 1 > DW + 1) ? PW + 1 : DW + 1;
  localparam int unsigned MW  = (M0 > CW + 1) ? M0 : CW + 1;
  localparam int unsigned PRW = 2 * MW;
  localparam int unsigned AW  = PRW + 1;
  localparam int unsigned RW  = PRW + 1;
  localparam int unsigned SW  = tbr_pkg::VTX_W + 2;
  localparam int unsigned AD  = tbr_pkg::ADDR_W;

  localparam logic signed [MW-1:0] ONE  = MW'(1) << F;
  localparam logic signed [RW-1:0] HALF = RW'(1) << (F - 1);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_D0   = 13'b0000000000010,
    S_D1   = 13'b0000000000100,
    S_D2   = 13'b0000000001000,
    S_A0   = 13'b0000000010000,
    S_A1   = 13'b0000000100000,
    S_A2   = 13'b0000001000000,
    S_A3   = 13'b0000010000000,
    S_A4   = 13'b0000100000000,
    S_A5   = 13'b0001000000000,
    S_A6   = 13'b0010000000000,
    S_A7   = 13'b0100000000000,
    S_A8   = 13'b1000000000000
  } state_e;

  state_e st_q, st_d;

  logic [tbr_pkg::DIM_W-1:0]  fb_w_q, fb_h_q;
  logic [tbr_pkg::STEP_W-1:0] x_step_q, y_step_q;
  logic [AD-1:0]              base_q;

  logic signed [VW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic signed [VW-1:0] min_x_q, max_x_q, max_y_q, sx_q, sy_q;
  logic                 walk_q;
  logic signed [AW-1:0] div_q, na_q, nb_q;
  logic signed [RW-1:0] px_q, py_q;
  logic                 cov_q, outs_q;

  logic                       out_vld_q;
  logic                       o_cov_q, o_outs_q, o_done_q;
  logic signed [tbr_pkg::PIX_W-1:0] o_px_q, o_py_q;
  logic [AD-1:0]              o_addr_q;

  logic signed [MW-1:0]  opa, opb;
  logic signed [PRW-1:0] prod;

  logic in_acc;
  assign in_i.ready = (st_q == S_IDLE) && !out_vld_q;
  assign in_acc     = in_i.valid && in_i.ready;

  // clamped sizes and half sizes
  logic [CW-1:0] cw, ch, hx, hy;
  assign cw = (CW'(fb_w_q) > CW'(MAX_FB_DIM)) ? CW'(MAX_FB_DIM) : CW'(fb_w_q);
  assign ch = (CW'(fb_h_q) > CW'(MAX_FB_DIM)) ? CW'(MAX_FB_DIM) : CW'(fb_h_q);
  assign hx = cw >> 1;
  assign hy = ch >> 1;

  // edge differences
  logic signed [DW-1:0] d_bc_y, d_cb_x, d_ca_y, d_ac_x, d_ac_y, d_sc_x, d_sc_y;
  assign d_bc_y = DW'(by_q) - DW'(cy_q);
  assign d_cb_x = DW'(cx_q) - DW'(bx_q);
  assign d_ca_y = DW'(cy_q) - DW'(ay_q);
  assign d_ac_x = DW'(ax_q) - DW'(cx_q);
  assign d_ac_y = DW'(ay_q) - DW'(cy_q);
  assign d_sc_x = DW'(sx_q) - DW'(cx_q);
  assign d_sc_y = DW'(sy_q) - DW'(cy_q);

  always_comb begin
    opa = '0;
    opb = '0;
    case (st_q)
      S_D0: begin opa = MW'(d_bc_y); opb = MW'(d_ac_x); end
      S_D1: begin opa = MW'(d_cb_x); opb = MW'(d_ac_y); end
      S_A0: begin opa = MW'(d_bc_y); opb = MW'(d_sc_x); end
      S_A1: begin opa = MW'(d_cb_x); opb = MW'(d_sc_y); end
      S_A2: begin opa = MW'(d_ca_y); opb = MW'(d_sc_x); end
      S_A3: begin opa = MW'(d_ac_x); opb = MW'(d_sc_y); end
      S_A4: begin opa = MW'($signed({1'b0, hx})); opb = MW'(sx_q) + ONE; end
      S_A5: begin opa = MW'($signed({1'b0, hy})); opb = MW'(sy_q) + ONE; end
      S_A7: begin
        opa = MW'($signed({1'b0, py_q[CW-1:0]}));
        opb = MW'($signed({1'b0, cw}));
      end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  tbr_mul #(.MW(MW)) u_mul (
    .clk_i (clk_i),
    .a_i   (opa),
    .b_i   (opb),
    .prod_o(prod)
  );

  // round half away from zero, drop the fraction
  function automatic logic signed [RW-1:0] rnd(input logic signed [PRW-1:0] v);
    logic signed [RW-1:0] mag;
    logic signed [RW-1:0] q;
    mag = (v < 0) ? -RW'(v) : RW'(v);
    q   = (mag + HALF) >>> F;
    return (v < 0) ? -q : q;
  endfunction

  function automatic logic signed [tbr_pkg::PIX_W-1:0] sat(input logic signed [RW-1:0] p);
    logic signed [tbr_pkg::PIX_W-1:0] r;
    if (p > RW'(tbr_pkg::PIX_MAX)) r = tbr_pkg::PIX_MAX;
    else if (p < RW'(tbr_pkg::PIX_MIN)) r = tbr_pkg::PIX_MIN;
    else r = p[tbr_pkg::PIX_W-1:0];
    return r;
  endfunction

  // load-time box
  logic signed [VW-1:0] mnx, mxx, mny, mxy, t0, t1, t2, t3;
  always_comb begin
    t0  = (in_i.vertex_a_x < in_i.vertex_b_x) ? in_i.vertex_a_x : in_i.vertex_b_x;
    mnx = (t0 < in_i.vertex_c_x) ? t0 : in_i.vertex_c_x;
    t1  = (in_i.vertex_a_x > in_i.vertex_b_x) ? in_i.vertex_a_x : in_i.vertex_b_x;
    mxx = (t1 > in_i.vertex_c_x) ? t1 : in_i.vertex_c_x;
    t2  = (in_i.vertex_a_y < in_i.vertex_b_y) ? in_i.vertex_a_y : in_i.vertex_b_y;
    mny = (t2 < in_i.vertex_c_y) ? t2 : in_i.vertex_c_y;
    t3  = (in_i.vertex_a_y > in_i.vertex_b_y) ? in_i.vertex_a_y : in_i.vertex_b_y;
    mxy = (t3 > in_i.vertex_c_y) ? t3 : in_i.vertex_c_y;
  end

  logic signed [AW+1:0] nc;
  assign nc = (AW+2)'(div_q) - (AW+2)'(na_q) - (AW+2)'(nb_q);

  logic signed [SW-1:0] nx, ny;
  assign nx = SW'(sx_q) + SW'($signed({1'b0, x_step_q}));
  assign ny = SW'(sy_q) + SW'($signed({1'b0, y_step_q}));

  logic [AD-1:0] lin;
  assign lin = AD'(px_q[CW-1:0]) + AD'(prod[2*CW-1:0]);

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (in_acc) begin
        if (in_i.opcode == tbr_pkg::OP_LOAD) st_d = S_D0;
        else if (walk_q) st_d = S_A0;
      end
      S_D0: st_d = S_D1;
      S_D1: st_d = S_D2;
      S_D2: st_d = S_IDLE;
      S_A0: st_d = S_A1;
      S_A1: st_d = S_A2;
      S_A2: st_d = S_A3;
      S_A3: st_d = S_A4;
      S_A4: st_d = S_A5;
      S_A5: st_d = S_A6;
      S_A6: st_d = S_A7;
      S_A7: st_d = S_A8;
      S_A8: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      fb_w_q    <= tbr_pkg::FB_WIDTH_RST;
      fb_h_q    <= tbr_pkg::FB_HEIGHT_RST;
      x_step_q  <= tbr_pkg::X_STEP_RST;
      y_step_q  <= tbr_pkg::Y_STEP_RST;
      base_q    <= '0;
      ax_q <= '0; ay_q <= '0; bx_q <= '0; by_q <= '0; cx_q <= '0; cy_q <= '0;
      min_x_q   <= '0;
      max_x_q   <= '0;
      max_y_q   <= '0;
      sx_q      <= '0;
      sy_q      <= '0;
      walk_q    <= 1'b0;
      div_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tbr_pkg::CFG_FB_WIDTH:  fb_w_q   <= cfg_data_i[tbr_pkg::DIM_W-1:0];
          tbr_pkg::CFG_FB_HEIGHT: fb_h_q   <= cfg_data_i[tbr_pkg::DIM_W-1:0];
          tbr_pkg::CFG_X_STEP:    x_step_q <= cfg_data_i[tbr_pkg::STEP_W-1:0];
          tbr_pkg::CFG_Y_STEP:    y_step_q <= cfg_data_i[tbr_pkg::STEP_W-1:0];
          tbr_pkg::CFG_BASE:      base_q   <= cfg_data_i[AD-1:0];
          default: ;
        endcase
      end
      if (res_o.valid && res_o.ready) out_vld_q <= 1'b0;
      case (st_q)
        S_IDLE: if (in_acc) begin
          if (in_i.opcode == tbr_pkg::OP_LOAD) begin
            ax_q <= in_i.vertex_a_x; ay_q <= in_i.vertex_a_y;
            bx_q <= in_i.vertex_b_x; by_q <= in_i.vertex_b_y;
            cx_q <= in_i.vertex_c_x; cy_q <= in_i.vertex_c_y;
            min_x_q <= mnx;
            max_x_q <= mxx;
            max_y_q <= mxy;
            sx_q    <= mnx;
            sy_q    <= mny;
            walk_q  <= (mnx < mxx) && (mny < mxy);
          end else if (!walk_q) begin
            out_vld_q <= 1'b1;
          end
        end
        S_D1: div_q <= AW'(prod);
        S_D2: div_q <= div_q + AW'(prod);
        S_A8: begin
          out_vld_q <= 1'b1;
          if (nx < SW'(max_x_q)) begin
            sx_q <= nx[VW-1:0];
          end else begin
            sx_q <= min_x_q;
            if (ny < SW'(max_y_q)) sy_q <= ny[VW-1:0];
            else walk_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath and result payload
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: if (in_acc && in_i.opcode != tbr_pkg::OP_LOAD && !walk_q) begin
        o_cov_q  <= 1'b0;
        o_px_q   <= '0;
        o_py_q   <= '0;
        o_outs_q <= 1'b0;
        o_addr_q <= '0;
        o_done_q <= 1'b1;
      end
      S_A1: na_q <= AW'(prod);
      S_A2: na_q <= na_q + AW'(prod);
      S_A3: nb_q <= AW'(prod);
      S_A4: nb_q <= nb_q + AW'(prod);
      S_A5: begin
        px_q <= rnd(prod);
        if (div_q > 0)      cov_q <= (na_q >= 0) && (nb_q >= 0) && (nc >= 0);
        else if (div_q < 0) cov_q <= (na_q <= 0) && (nb_q <= 0) && (nc <= 0);
        else                cov_q <= 1'b0;
      end
      S_A6: py_q <= rnd(prod);
      S_A7: outs_q <= (px_q < 0) || (py_q < 0) || (px_q >= RW'($signed({1'b0, cw})))
                      || (py_q >= RW'($signed({1'b0, ch})));
      S_A8: begin
        o_cov_q  <= cov_q;
        o_px_q   <= sat(px_q);
        o_py_q   <= sat(py_q);
        o_outs_q <= outs_q;
        o_addr_q <= outs_q ? '0 : base_q + (lin << 2);
        o_done_q <= !(nx < SW'(max_x_q)) && !(ny < SW'(max_y_q));
      end
      default: ;
    endcase
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.covered       = o_cov_q;
  assign res_o.pixel_x       = o_px_q;
  assign res_o.pixel_y       = o_py_q;
  assign res_o.outside       = o_outs_q;
  assign res_o.pixel_address = o_addr_q;
  assign res_o.done_res      = o_done_q;
endmodule
